[src/stq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_pkg
// shared codes and field widths of the sorted timer queue
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int unsigned OP_W   = 3;
  localparam int unsigned SLOT_W = 5;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned DEST_W = 4;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CFG_W  = 6;

  localparam logic [CFG_W-1:0] SWITCH_NONE = 6'd32;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 3'd0,
    OP_FREE    = 3'd1,
    OP_INIT    = 3'd2,
    OP_SETTIME = 3'd3,
    OP_TICK    = 3'd4
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_GRANT  = 3'd0,
    KIND_NOFREE = 3'd1,
    KIND_ACK    = 3'd2,
    KIND_EXPIRY = 3'd3,
    KIND_SWITCH = 3'd4
  } kind_t;

endpackage : stq_pkg
`default_nettype wire

[src/stq_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq interfaces
// request, response and configuration channels of the timer queue
// ----------------------------------------------------------------------------
interface stq_req_if import stq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   operation;
  logic [SLOT_W-1:0] slot_index;
  logic [DATA_W-1:0] delay_ticks;
  logic [DATA_W-1:0] payload;
  logic [DEST_W-1:0] destination;
  modport source (output valid, operation, slot_index, delay_ticks, payload,
                  destination, input ready);
  modport sink   (input valid, operation, slot_index, delay_ticks, payload,
                  destination, output ready);
endinterface

interface stq_rsp_if import stq_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [SLOT_W-1:0] timer_slot;
  logic [DATA_W-1:0] event_data;
  logic [DEST_W-1:0] event_target;
  logic              last;
  modport source (output valid, kind, timer_slot, event_data, event_target, last,
                  input ready);
  modport sink   (input valid, kind, timer_slot, event_data, event_target, last,
                  output ready);
endinterface

interface stq_cfg_if import stq_pkg::*;;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

[src/stq_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_ram
// generic single write, single registered read memory
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

[src/sorted_timer_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_timer_queue_core
// timer pool with one deadline-ordered linked list walked by a small sequencer
// ----------------------------------------------------------------------------
// init and unknown ops answer with one ack beat; alloc scans for the lowest free slot
// free walks the list to unlink an armed slot; settime unlinks it the same way, then
// walks the list again to insert it, linking at the head or behind the previous node
// tick expires due heads in list order, then sends the last beat and, on a task switch,
// a switch beat; the response side can stall it; one item at a time, one read a node
// reset clears status, list head, tick count and switch register; no clearing pass
// ----------------------------------------------------------------------------
module sorted_timer_queue_core import stq_pkg::*; #(
  parameter int unsigned TIMER_SLOTS = 32
) (
  input wire logic   clk,
  input wire logic   rst,
  stq_req_if.sink    req,
  stq_rsp_if.source  rsp,
  stq_cfg_if.sink    cfg
);
  // pointer holds a slot or the end-of-list mark TIMER_SLOTS
  localparam int unsigned PW = $clog2(TIMER_SLOTS + 1);
  localparam int unsigned AW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam logic [PW-1:0] NIL = PW'(TIMER_SLOTS);

  typedef logic [PW-1:0] ptr_t;

  typedef enum logic [3:0] {
    S_IDLE, S_ALLOC, S_UL_RD, S_UL_CHK, S_INS_START, S_INS_RD, S_INS_CHK,
    S_INS_LINK, S_INS_LINK2, S_TK_RD, S_TK_CHK, S_TK_END, S_TK_SW, S_ACK
  } state_t;

  state_t            state;
  op_t               op;
  ptr_t              slot;       // addressed slot, only meaningful when in range
  logic [SLOT_W-1:0] slot_raw;
  logic [DATA_W-1:0] new_dl;
  logic [DATA_W-1:0] tick_count;
  logic [CFG_W-1:0]  sw_idx;
  ptr_t              head;
  ptr_t              cur;
  ptr_t              prev;
  ptr_t              guard;
  logic [TIMER_SLOTS-1:0] used;
  logic [TIMER_SLOTS-1:0] armed;

  // pending expiry, held back until we know whether it is the final beat
  logic              pend_v;
  ptr_t              pend_slot;
  logic [DATA_W-1:0] pend_data;
  logic [DEST_W-1:0] pend_tgt;
  logic              sw_hit;

  // response register
  logic              o_valid;
  kind_t             o_kind;
  logic [SLOT_W-1:0] o_slot;
  logic [DATA_W-1:0] o_data;
  logic [DEST_W-1:0] o_tgt;
  logic              o_last;

  // memories
  logic              dl_we, succ_we, pay_we;
  logic [AW-1:0]     dl_wa, succ_wa, pay_wa;
  logic [DATA_W-1:0] dl_wd;
  ptr_t              succ_wd;
  logic [DATA_W-1:0] dl_rd, pay_rd;
  ptr_t              succ_rd;
  logic [DEST_W-1:0] tgt_rd;
  logic [AW-1:0]     rd_addr;

  logic in_acc, out_free, slot_ok, cur_end, cur_is_sw;

  assign in_acc    = req.valid && req.ready;
  assign out_free  = !o_valid || rsp.ready;
  assign slot_ok   = 32'(req.slot_index) < 32'(TIMER_SLOTS);
  assign cur_end   = (cur == NIL) || (guard == NIL);
  assign cur_is_sw = 32'(cur) == 32'(sw_idx);
  assign rd_addr   = cur[AW-1:0];

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;

  assign rsp.valid        = o_valid;
  assign rsp.kind         = o_kind;
  assign rsp.timer_slot   = o_slot;
  assign rsp.event_data   = o_data;
  assign rsp.event_target = o_tgt;
  assign rsp.last         = o_last;

  // memory write ports
  always_comb begin
    dl_we   = (state == S_INS_START);
    dl_wa   = slot[AW-1:0];
    dl_wd   = new_dl;
    pay_we  = in_acc && (op_t'(req.operation) == OP_INIT) && slot_ok;
    pay_wa  = AW'(req.slot_index);
    succ_we = 1'b0;
    succ_wa = slot[AW-1:0];
    succ_wd = cur;
    unique case (state)
      S_UL_CHK: begin
        succ_we = (cur == slot) && (prev != NIL);
        succ_wa = prev[AW-1:0];
        succ_wd = succ_rd;
      end
      S_INS_LINK: begin
        succ_we = 1'b1;
      end
      S_INS_LINK2: begin
        succ_we = 1'b1;
        succ_wa = prev[AW-1:0];
        succ_wd = slot;
      end
      default: begin
      end
    endcase
  end

  stq_ram #(.WIDTH(DATA_W), .DEPTH(TIMER_SLOTS)) u_dl_ram (
    .clk(clk), .we(dl_we), .waddr(dl_wa), .wdata(dl_wd), .raddr(rd_addr), .rdata(dl_rd)
  );
  stq_ram #(.WIDTH(PW), .DEPTH(TIMER_SLOTS)) u_succ_ram (
    .clk(clk), .we(succ_we), .waddr(succ_wa), .wdata(succ_wd), .raddr(rd_addr),
    .rdata(succ_rd)
  );
  stq_ram #(.WIDTH(DATA_W), .DEPTH(TIMER_SLOTS)) u_pay_ram (
    .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(req.payload), .raddr(rd_addr),
    .rdata(pay_rd)
  );
  stq_ram #(.WIDTH(DEST_W), .DEPTH(TIMER_SLOTS)) u_tgt_ram (
    .clk(clk), .we(pay_we), .waddr(pay_wa), .wdata(req.destination), .raddr(rd_addr),
    .rdata(tgt_rd)
  );

  // sequencer, status bits and response register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      sw_idx     <= SWITCH_NONE;
      tick_count <= '0;
      head       <= NIL;
      used       <= '0;
      armed      <= '0;
      o_valid    <= 1'b0;
      pend_v     <= 1'b0;
      sw_hit     <= 1'b0;
    end else begin
      if (cfg.valid) begin
        sw_idx <= cfg.data;
      end
      if (rsp.ready) begin
        o_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            op       <= op_t'(req.operation);
            slot     <= PW'(req.slot_index);
            slot_raw <= req.slot_index;
            new_dl   <= req.delay_ticks + tick_count;
            cur      <= (op_t'(req.operation) == OP_ALLOC) ? '0 : head;
            prev     <= NIL;
            guard    <= '0;
            pend_v   <= 1'b0;
            sw_hit   <= 1'b0;
            case (req.operation)
              OP_ALLOC: state <= S_ALLOC;
              OP_TICK: begin
                tick_count <= tick_count + 1'b1;
                state      <= S_TK_RD;
              end
              OP_FREE, OP_SETTIME: begin
                if (!slot_ok) begin
                  state <= S_ACK;
                end else if (armed[req.slot_index[AW-1:0]]) begin
                  state <= S_UL_RD;
                end else if (op_t'(req.operation) == OP_FREE) begin
                  used[req.slot_index[AW-1:0]] <= 1'b0;
                  state <= S_ACK;
                end else begin
                  state <= S_INS_START;
                end
              end
              default: state <= S_ACK;
            endcase
          end
        end
        // lowest free slot, one per cycle
        S_ALLOC: begin
          if (cur == NIL) begin
            if (out_free) begin
              o_valid <= 1'b1; o_kind <= KIND_NOFREE; o_slot <= '0;
              o_data <= '0; o_tgt <= '0; o_last <= 1'b1;
              state <= S_IDLE;
            end
          end else if (!used[cur[AW-1:0]]) begin
            if (out_free) begin
              used[cur[AW-1:0]] <= 1'b1;
              o_valid <= 1'b1; o_kind <= KIND_GRANT; o_slot <= SLOT_W'(cur);
              o_data <= '0; o_tgt <= '0; o_last <= 1'b1;
              state <= S_IDLE;
            end
          end else begin
            cur <= cur + 1'b1;
          end
        end
        // take the slot out of the list
        S_UL_RD: begin
          state <= cur_end ? ((op == OP_FREE) ? S_ACK : S_INS_START) : S_UL_CHK;
          if (cur_end && op == OP_FREE) begin
            used[slot[AW-1:0]]  <= 1'b0;
            armed[slot[AW-1:0]] <= 1'b0;
          end
        end
        S_UL_CHK: begin
          if (cur == slot) begin
            if (prev == NIL) begin
              head <= succ_rd;
            end
            if (op == OP_FREE) begin
              used[slot[AW-1:0]]  <= 1'b0;
              armed[slot[AW-1:0]] <= 1'b0;
              state <= S_ACK;
            end else begin
              state <= S_INS_START;
            end
          end else begin
            prev  <= cur;
            cur   <= succ_rd;
            guard <= guard + 1'b1;
            state <= S_UL_RD;
          end
        end
        // file the slot in by deadline, newer first on a tie
        S_INS_START: begin
          used[slot[AW-1:0]]  <= 1'b1;
          armed[slot[AW-1:0]] <= 1'b1;
          cur   <= head;
          prev  <= NIL;
          guard <= '0;
          state <= S_INS_RD;
        end
        S_INS_RD: begin
          state <= cur_end ? S_INS_LINK : S_INS_CHK;
        end
        S_INS_CHK: begin
          if (new_dl <= dl_rd) begin
            state <= S_INS_LINK;
          end else begin
            prev  <= cur;
            cur   <= succ_rd;
            guard <= guard + 1'b1;
            state <= S_INS_RD;
          end
        end
        S_INS_LINK: begin
          if (prev == NIL) begin
            head  <= slot;
            state <= S_ACK;
          end else begin
            state <= S_INS_LINK2;
          end
        end
        S_INS_LINK2: begin
          state <= S_ACK;
        end
        // expire due heads in list order
        S_TK_RD: begin
          state <= cur_end ? S_TK_END : S_TK_CHK;
        end
        S_TK_CHK: begin
          if (dl_rd > tick_count) begin
            state <= S_TK_END;
          end else if (cur_is_sw || !pend_v || out_free) begin
            used[cur[AW-1:0]]  <= 1'b1;
            armed[cur[AW-1:0]] <= 1'b0;
            head  <= succ_rd;
            cur   <= succ_rd;
            guard <= guard + 1'b1;
            state <= S_TK_RD;
            if (cur_is_sw) begin
              sw_hit <= 1'b1;
            end else begin
              if (pend_v) begin
                o_valid <= 1'b1; o_kind <= KIND_EXPIRY; o_slot <= SLOT_W'(pend_slot);
                o_data <= pend_data; o_tgt <= pend_tgt; o_last <= 1'b0;
              end
              pend_v    <= 1'b1;
              pend_slot <= cur;
              pend_data <= pay_rd;
              pend_tgt  <= tgt_rd;
            end
          end
        end
        S_TK_END: begin
          if (!pend_v) begin
            state <= sw_hit ? S_TK_SW : S_IDLE;
          end else if (out_free) begin
            o_valid <= 1'b1; o_kind <= KIND_EXPIRY; o_slot <= SLOT_W'(pend_slot);
            o_data <= pend_data; o_tgt <= pend_tgt; o_last <= !sw_hit;
            pend_v <= 1'b0;
            state  <= sw_hit ? S_TK_SW : S_IDLE;
          end
        end
        S_TK_SW: begin
          if (out_free) begin
            o_valid <= 1'b1; o_kind <= KIND_SWITCH; o_slot <= SLOT_W'(sw_idx);
            o_data <= '0; o_tgt <= '0; o_last <= 1'b1;
            state <= S_IDLE;
          end
        end
        S_ACK: begin
          if (out_free) begin
            o_valid <= 1'b1; o_kind <= KIND_ACK; o_slot <= slot_raw;
            o_data <= '0; o_tgt <= '0; o_last <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

[src/stq_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stq_chk
// port-level checks of the timer queue, bound to the top level
// ----------------------------------------------------------------------------
module stq_chk import stq_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [KIND_W-1:0] out_kind,
  input wire logic [DATA_W-1:0] out_data,
  input wire logic              out_last
);
  // busy after every accepted beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("ready while busy");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind == KIND_GRANT || out_kind == KIND_NOFREE ||
                   out_kind == KIND_ACK || out_kind == KIND_EXPIRY ||
                   out_kind == KIND_SWITCH)) else $error("bad kind");

  a_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_EXPIRY |-> out_data == '0) else $error("stray data");

  a_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_kind != KIND_EXPIRY |-> out_last) else $error("missing last");

  // a waiting beat stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_data) &&
                                $stable(out_last)) else $error("beat dropped");

  a_rst: assert property (@(posedge clk) rst |=> !out_valid) else $error("valid after reset");
endmodule

bind sorted_timer_queue_core stq_chk u_stq_chk (
  .clk(clk), .rst(rst),
  .in_valid(req.valid), .in_ready(req.ready),
  .out_valid(rsp.valid), .out_ready(rsp.ready), .out_kind(rsp.kind),
  .out_data(rsp.event_data), .out_last(rsp.last)
);
`default_nettype wire

[dv/sorted_timer_queue_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_timer_queue_core_tb
// checks the timer pool against its own deadline-list predictor: directed
// corner cases, then random operation mixes under several switch-timer
// settings, with random idling on both channels and a long response stall
// ----------------------------------------------------------------------------
module sorted_timer_queue_core_tb;
  import stq_pkg::*;

  localparam int unsigned SLOTS     = 32;
  localparam int unsigned IDLE_PCT  = 17;
  localparam int unsigned HOLD_LEN  = 400;  // long response stall, in cycles
  localparam int unsigned SETTLE    = 100;  // quiet cycles after a drain
  localparam int unsigned WDOG_MAX  = 5000; // cycles with no beat at all
  localparam logic [OP_W-1:0] OP_CODE_MAX = 3'd7;
  localparam logic [DATA_W-1:0] ALL_ONES = 32'hffff_ffff;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] delay;
    logic [DATA_W-1:0] payload;
    logic [DEST_W-1:0] dest;
  } timer_op_t;

  typedef struct packed {
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] data;
    logic [DEST_W-1:0] target;
    logic              last;
  } timer_evt_t;

  logic clk;
  logic rst;

  stq_req_if req ();
  stq_rsp_if rsp ();
  stq_cfg_if cfg ();

  sorted_timer_queue_core #(.TIMER_SLOTS(SLOTS)) DUT (
    .clk (clk),
    .rst (rst),
    .req (req.sink),
    .rsp (rsp.source),
    .cfg (cfg.sink)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // stimulus and expectation stores
  timer_op_t  pending_ops[$];
  timer_evt_t due_events[$];
  int         errors = 0;

  // shadow of the timer pool
  logic [1:0]        sh_status[SLOTS];
  logic [DATA_W-1:0] sh_deadline[SLOTS];
  logic [DATA_W-1:0] sh_payload[SLOTS];
  logic [DEST_W-1:0] sh_target[SLOTS];
  logic [5:0]        sh_next[SLOTS];
  logic [5:0]        sh_head;
  logic [DATA_W-1:0] sh_due;
  logic [DATA_W-1:0] sh_ticks;
  logic [CFG_W-1:0]  sh_switch;

  // generator bookkeeping: slots whose payload has been written
  logic [SLOTS-1:0] inited = '0;
  logic [CFG_W-1:0] switch_pick = SWITCH_NONE;

  // idling control
  bit steady = 1'b0;
  bit hold_req = 1'b0;
  bit hold_seen = 1'b0;
  int hold_cnt = 0;
  bit req_took = 1'b0;
  int quiet_cycles = 0;

  function automatic void refresh_due();
    sh_due = (sh_head < SLOTS) ? sh_deadline[sh_head[4:0]] : ALL_ONES;
  endfunction

  function automatic void drop_from_list(input logic [4:0] s);
    logic [5:0] prev;
    logic [5:0] cur;
    int guard;
    prev = SLOTS;
    cur = sh_head;
    guard = 0;
    while (cur < SLOTS && guard < SLOTS) begin
      if (cur == s) begin
        if (prev < SLOTS) sh_next[prev[4:0]] = sh_next[cur[4:0]];
        else sh_head = sh_next[cur[4:0]];
        break;
      end
      prev = cur;
      cur = sh_next[cur[4:0]];
      guard++;
    end
    refresh_due();
  endfunction

  // newer timer goes ahead of older ones with the same deadline
  function automatic void file_into_list(input logic [4:0] s);
    logic [5:0] prev;
    logic [5:0] cur;
    int guard;
    prev = SLOTS;
    cur = sh_head;
    guard = 0;
    while (cur < SLOTS && guard < SLOTS) begin
      if (sh_deadline[s] <= sh_deadline[cur[4:0]]) break;
      prev = cur;
      cur = sh_next[cur[4:0]];
      guard++;
    end
    sh_next[s] = cur;
    if (prev < SLOTS) sh_next[prev[4:0]] = {1'b0, s};
    else sh_head = {1'b0, s};
    refresh_due();
  endfunction

  function automatic timer_evt_t mk_evt(input kind_t k, input logic [4:0] s,
                                        input logic [DATA_W-1:0] d,
                                        input logic [DEST_W-1:0] t);
    timer_evt_t e;
    e.kind = k;
    e.slot = s;
    e.data = d;
    e.target = t;
    e.last = 1'b0;
    return e;
  endfunction

  // works out the beats that one accepted operation must produce
  function automatic void predict_events(input timer_op_t it);
    timer_evt_t burst[$];
    timer_evt_t e;
    logic [5:0] h;
    int i;
    int guard;
    bit sw;
    sw = 1'b0;
    case (it.op)
      OP_ALLOC: begin
        for (i = 0; i < SLOTS; i++) if (sh_status[i] == 2'd0) break;
        if (i < SLOTS) begin
          sh_status[i] = 2'd1;
          burst.push_back(mk_evt(KIND_GRANT, i[4:0], '0, '0));
        end else begin
          burst.push_back(mk_evt(KIND_NOFREE, '0, '0, '0));
        end
      end
      OP_TICK: begin
        sh_ticks = sh_ticks + 1;
        if (sh_due <= sh_ticks) begin
          guard = 0;
          while (sh_head < SLOTS && guard < SLOTS &&
                 sh_deadline[sh_head[4:0]] <= sh_ticks) begin
            h = sh_head;
            sh_status[h[4:0]] = 2'd1;
            if (h == sh_switch) sw = 1'b1;
            else burst.push_back(mk_evt(KIND_EXPIRY, h[4:0], sh_payload[h[4:0]],
                                        sh_target[h[4:0]]));
            sh_head = sh_next[h[4:0]];
            guard++;
          end
          refresh_due();
          if (sw) burst.push_back(mk_evt(KIND_SWITCH, sh_switch[4:0], '0, '0));
        end
      end
      default: begin
        // free, init, settime and unknown codes all answer with one ack
        if (it.op == OP_FREE) begin
          if (sh_status[it.slot] == 2'd2) drop_from_list(it.slot);
          sh_status[it.slot] = 2'd0;
        end else if (it.op == OP_INIT) begin
          sh_payload[it.slot] = it.payload;
          sh_target[it.slot] = it.dest;
        end else if (it.op == OP_SETTIME) begin
          if (sh_status[it.slot] == 2'd2) drop_from_list(it.slot);
          sh_deadline[it.slot] = it.delay + sh_ticks;
          sh_status[it.slot] = 2'd2;
          file_into_list(it.slot);
        end
        burst.push_back(mk_evt(KIND_ACK, it.slot, '0, '0));
      end
    endcase
    if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[k]) due_events.push_back(burst[k]);
  endfunction

  function automatic timer_op_t mk_op(input logic [OP_W-1:0] op, input logic [4:0] s,
                                      input logic [DATA_W-1:0] dl,
                                      input logic [DATA_W-1:0] pl,
                                      input logic [DEST_W-1:0] ds);
    timer_op_t it;
    it.op = op;
    it.slot = s;
    it.delay = dl;
    it.payload = pl;
    it.dest = ds;
    return it;
  endfunction

  // mostly short delays so that timers actually fall due
  function automatic logic [DATA_W-1:0] pick_delay();
    int r;
    r = $urandom_range(99);
    if (r < 65) return $urandom_range(6);
    if (r < 88) return $urandom_range(40);
    if (r < 93) return ALL_ONES - $urandom_range(3);
    return $urandom;
  endfunction

  // random operation; settime only on slots with a written payload
  function automatic timer_op_t next_op();
    timer_op_t it;
    int r;
    logic [4:0] s;
    it = mk_op(OP_TICK, 5'($urandom), $urandom, $urandom, 4'($urandom));
    r = $urandom_range(99);
    s = 5'($urandom);
    if (r < 14) it.op = OP_ALLOC;
    else if (r < 24) it.op = OP_FREE;
    else if (r < 36) it.op = OP_INIT;
    else if (r < 66) begin
      if (switch_pick < SLOTS && inited[switch_pick[4:0]] && $urandom_range(9) == 0)
        s = switch_pick[4:0];
      it.op = inited[s] ? OP_SETTIME : OP_INIT;
      it.delay = pick_delay();
    end else if (r < 95) it.op = OP_TICK;
    else it.op = $urandom_range(OP_TICK + 1, OP_CODE_MAX);
    it.slot = s;
    return it;
  endfunction

  task automatic offer(input timer_op_t it);
    if (it.op == OP_INIT) inited[it.slot] = 1'b1;
    pending_ops.push_back(it);
  endtask

  task automatic write_switch(input logic [CFG_W-1:0] v);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // wait until every offered op is in and every beat is out, then settle
  task automatic drain();
    do @(posedge clk);
    while (pending_ops.size() != 0 || req.valid || due_events.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] sw, input int n,
                              input bit calm, input bit stall);
    write_switch(sw);
    switch_pick = sw;
    steady = calm;
    if (stall) hold_req = ~hold_req;
    repeat (n) offer(next_op());
    drain();
    steady = 1'b0;
  endtask

  // request driver: new beat at the falling edge once the last one was taken
  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
    end else if (!req.valid || req_took) begin
      if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
        timer_op_t it;
        it = pending_ops.pop_front();
        req.valid <= 1'b1;
        req.operation <= it.op;
        req.slot_index <= it.slot;
        req.delay_ticks <= it.delay;
        req.payload <= it.payload;
        req.destination <= it.dest;
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // response ready: random idling, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_cnt > 0) begin
      rsp.ready <= 1'b0;
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_cnt <= HOLD_LEN;
      rsp.ready <= 1'b0;
    end else begin
      rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: checks response beats, predicts on request beats, watchdog
  always @(posedge clk) begin
    timer_evt_t want;
    timer_op_t got;
    req_took = 1'b0;
    if (!rst) begin
      if (cfg.valid && cfg.ready) sh_switch = cfg.data;
      if (rsp.valid && rsp.ready) begin
        if (due_events.size() == 0) begin
          $error("unexpected beat: kind %0d slot %0d", rsp.kind, rsp.timer_slot);
          errors++;
        end else begin
          want = due_events.pop_front();
          if (rsp.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, rsp.kind);
            errors++;
          end
          if (rsp.timer_slot !== want.slot) begin
            $error("timer_slot: expected %0d, got %0d", want.slot, rsp.timer_slot);
            errors++;
          end
          if (rsp.event_data !== want.data) begin
            $error("event_data: expected %h, got %h", want.data, rsp.event_data);
            errors++;
          end
          if (rsp.event_target !== want.target) begin
            $error("event_target: expected %0d, got %0d", want.target, rsp.event_target);
            errors++;
          end
          if (rsp.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, rsp.last);
            errors++;
          end
        end
      end
      if (req.valid && req.ready) begin
        req_took = 1'b1;
        got = mk_op(req.operation, req.slot_index, req.delay_ticks, req.payload,
                    req.destination);
        predict_events(got);
      end
      if (req_took || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WDOG_MAX) begin
        $display("sorted_timer_queue_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    req.valid = 1'b0;
    req.operation = '0;
    req.slot_index = '0;
    req.delay_ticks = '0;
    req.payload = '0;
    req.destination = '0;
    rsp.ready = 1'b0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    foreach (sh_status[i]) sh_status[i] = 2'd0;
    sh_head = SLOTS;
    sh_due = ALL_ONES;
    sh_ticks = '0;
    sh_switch = SWITCH_NONE;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed corner cases, slot 5 is the switch timer
    write_switch(6'd5);
    offer(mk_op(OP_ALLOC, 5'd0, '0, '0, '0));
    offer(mk_op(OP_INIT, 5'd0, '0, ALL_ONES, 4'hf));
    offer(mk_op(OP_INIT, 5'd31, ALL_ONES, '0, 4'h0));
    offer(mk_op(OP_INIT, 5'd5, '0, 32'ha5a5_5a5a, 4'ha));
    offer(mk_op(OP_SETTIME, 5'd0, 32'd2, '0, '0));
    // same deadline as slot 0: the newer one leads
    offer(mk_op(OP_SETTIME, 5'd5, 32'd2, '0, '0));
    offer(mk_op(OP_SETTIME, 5'd31, ALL_ONES, '0, '0));
    // nothing due yet
    offer(mk_op(OP_TICK, '0, '0, '0, '0));
    // re-arm an armed slot
    offer(mk_op(OP_SETTIME, 5'd0, 32'd5, '0, '0));
    // only the switch timer falls due: one switch beat, no expiry
    offer(mk_op(OP_TICK, '0, '0, '0, '0));
    // free of an armed slot, then of an unused one
    offer(mk_op(OP_FREE, 5'd31, '0, '0, '0));
    offer(mk_op(OP_FREE, 5'd7, '0, '0, '0));
    for (int c = OP_TICK + 1; c <= OP_CODE_MAX; c++)
      offer(mk_op(c[OP_W-1:0], 5'd31, ALL_ONES, ALL_ONES, 4'hf));
    // deadline wraps past zero and falls due at the next tick
    offer(mk_op(OP_SETTIME, 5'd31, ALL_ONES, '0, '0));
    offer(mk_op(OP_TICK, '0, '0, '0, '0));
    // zero delay: due at the next tick
    offer(mk_op(OP_SETTIME, 5'd0, '0, '0, '0));
    offer(mk_op(OP_SETTIME, 5'd5, 32'd1, '0, '0));
    offer(mk_op(OP_TICK, '0, '0, '0, '0));
    offer(mk_op(OP_TICK, '0, '0, '0, '0));
    drain();

    // random mixes under several switch settings
    random_phase(SWITCH_NONE, 90, 1'b1, 1'b0);
    random_phase(6'd0, 90, 1'b0, 1'b1);
    random_phase(6'd31, 90, 1'b0, 1'b0);
    random_phase(6'd63, 90, 1'b0, 1'b0);
    random_phase(6'($urandom_range(SLOTS - 1)), 90, 1'b0, 1'b0);

    if (errors == 0) begin
      $display("sorted_timer_queue_core_tb OK");
    end else begin
      $display("sorted_timer_queue_core_tb NOT OK");
    end
    $finish;
  end

endmodule

[files.f]
src/stq_pkg.sv
src/stq_if.sv
src/stq_ram.sv
src/sorted_timer_queue_core.sv
src/stq_chk.sv
dv/sorted_timer_queue_core_tb.sv
